// ----- rtl/core/hbdss_pkg.sv -----
// Shared types, constants and helpers for the H-bridge direction / soft-stop PWM block.
// No dependencies; used by the channel interfaces and the top level.
package hbdss_pkg;

  // Field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned CmpW    = 16;
  localparam int unsigned LevelW  = 22;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PaddrW  = 4;

  // Duty levels are integers in units of 1/LevelScale of full duty
  localparam int unsigned LevelScale = 4095000;
  localparam int unsigned AdcFull    = 4095;
  localparam int unsigned RefGain    = LevelScale / AdcFull;

  // level * period / LevelScale through an exact reciprocal multiply.
  // Dividend < 2^ProdW, LevelScale <= 2^22, so shift = ProdW + 22.
  localparam int unsigned ProdW      = LevelW + CmpW;
  localparam int unsigned RecipShift = ProdW + 22;
  localparam logic [63:0] RecipFull  =
    ((64'd1 << RecipShift) + 64'(LevelScale) - 64'd1) / 64'(LevelScale);
  localparam int unsigned RecipW     = 39;
  localparam int unsigned RecipLoW   = 20;
  localparam int unsigned XLoW       = 19;
  localparam int unsigned PpW        = RecipW;
  localparam int unsigned SumW       = ProdW + RecipW + 1;
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  // Register reset values
  localparam logic [CmpW-1:0]   PeriodRst   = 16'd17000;
  localparam logic [CmpW-1:0]   DeadRst     = 16'd680;
  localparam logic [CmpW-1:0]   MinCmpRst   = 16'd3;
  localparam logic [LevelW-1:0] RampStepRst = 22'd4095;
  localparam logic [CmpW-1:0]   HighCmpRst  = 16'd3;
  localparam logic [CmpW-1:0]   LowCmpRst   = 16'd683;

  typedef enum logic [1:0] {
    REG_PERIOD    = 2'd0,
    REG_DEAD      = 2'd1,
    REG_MIN_CMP   = 2'd2,
    REG_RAMP_STEP = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MODE_A    = 3'b001,
    MODE_B    = 3'b010,
    MODE_STOP = 3'b100
  } mode_e;

  localparam logic [ModeW-1:0] DriveA    = 2'd0;
  localparam logic [ModeW-1:0] DriveB    = 2'd1;
  localparam logic [ModeW-1:0] DriveStop = 2'd2;

  typedef enum logic [1:0] {
    HI_KEEP,
    HI_TICKS,
    HI_MIN
  } hi_sel_e;

  typedef enum logic [1:0] {
    LO_KEEP,
    LO_TICKS,
    LO_ARM
  } lo_sel_e;

  typedef struct packed {
    logic led;
    logic cnt;
    logic low;
    logic high;
  } flags_t;

  localparam flags_t FlagsRst = '{led: 1'b0, cnt: 1'b1, low: 1'b0, high: 1'b0};
  localparam flags_t FlagsLed = '{led: 1'b1, cnt: 1'b0, low: 1'b0, high: 1'b0};

  // Per-transaction control carried down the pipeline
  typedef struct packed {
    hi_sel_e          hi_sel;
    lo_sel_e          lo_sel;
    flags_t           flags;
    logic [ModeW-1:0] drive_mode;
  } ctrl_t;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] c;
    unique case (m)
      MODE_A:  c = DriveA;
      MODE_B:  c = DriveB;
      default: c = DriveStop;
    endcase
    return c;
  endfunction

  // Low-side compare limited to period - 1 (0 for a zero period)
  function automatic logic [CmpW-1:0] cap_low(logic [CmpW:0] v, logic [CmpW-1:0] period);
    logic [CmpW-1:0] r;
    if (v >= {1'b0, period}) begin
      r = (period == '0) ? '0 : period - 1'b1;
    end else begin
      r = v[CmpW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hbdss_if.sv -----
// Valid/ready channel interfaces for the tick input and the PWM result.
// Depends on hbdss_pkg for field widths.
interface hbdss_in_if;
  import hbdss_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;
  logic               adc_ok;
  logic               stop_press;
  logic               dir_press;

  modport source (output valid, adc_sample, adc_ok, stop_press, dir_press, input ready);
  modport sink   (input valid, adc_sample, adc_ok, stop_press, dir_press, output ready);
endinterface

interface hbdss_out_if;
  import hbdss_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmpW-1:0]  high_compare;
  logic [CmpW-1:0]  low_on_compare;
  logic             high_enable;
  logic             low_enable;
  logic             counter_run;
  logic             stop_led;
  logic [ModeW-1:0] drive_mode;

  modport source (output valid, high_compare, low_on_compare, high_enable, low_enable,
                  counter_run, stop_led, drive_mode, input ready);
  modport sink   (input valid, high_compare, low_on_compare, high_enable, low_enable,
                  counter_run, stop_led, drive_mode, output ready);
endinterface

// ----- rtl/core/hbridge_direction_soft_stop_pwm.sv -----
// H-bridge direction control with soft stop: drive state plus PWM compare pipeline.
// Depends on hbdss_pkg and the channel interfaces in hbdss_if.sv.
//
//  channel   | kind          | payload
//  ----------+---------------+---------------------------------------------------
//  in_i      | valid/ready   | adc_sample, adc_ok, stop_press, dir_press
//  out_o     | valid/ready   | high_compare, low_on_compare, enables, led, mode
//  apb       | APB write/read| period_ticks, dead_ticks, min_compare, ramp_step
//
// One transaction per cycle sustained while out_o.ready holds. Each result passes
// through state update, level x period, reciprocal partial products,
// partial product sum, compare select into the output register.
// Reset clears drive state and restores the register defaults; no clearing pass.
// A stalled output backs up the pipeline one stage at a time; in_i.ready drops
// only when every stage holds a transaction.
module hbridge_direction_soft_stop_pwm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hbdss_in_if.sink                     in_i,
  hbdss_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbdss_pkg::PaddrW-1:0] paddr,
  input  logic [hbdss_pkg::DataW-1:0]  pwdata,
  output logic [hbdss_pkg::DataW-1:0]  prdata,
  output logic                         pready
);
  import hbdss_pkg::*;

  // ---------------- configuration registers ----------------
  logic [CmpW-1:0]   period_q, dead_q, min_cmp_q;
  logic [LevelW-1:0] ramp_step_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[PaddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodRst;
      dead_q      <= DeadRst;
      min_cmp_q   <= MinCmpRst;
      ramp_step_q <= RampStepRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PERIOD:    period_q    <= pwdata[CmpW-1:0];
        REG_DEAD:      dead_q      <= pwdata[CmpW-1:0];
        REG_MIN_CMP:   min_cmp_q   <= pwdata[CmpW-1:0];
        REG_RAMP_STEP: ramp_step_q <= pwdata[LevelW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PERIOD:    prdata = DataW'(period_q);
      REG_DEAD:      prdata = DataW'(dead_q);
      REG_MIN_CMP:   prdata = DataW'(min_cmp_q);
      REG_RAMP_STEP: prdata = DataW'(ramp_step_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic en1, en2, en3, en4, en_out, in_acc;

  assign en_out     = !out_valid_q || out_o.ready;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;
  assign in_acc     = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= in_i.valid;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en_out) out_valid_q <= v4_q;
    end
  end

  // ---------------- stage 1: drive state update ----------------
  mode_e             mode_q, mode_d;
  logic              saved_q, saved_d;
  logic              toggle_q, toggle_d;
  logic [LevelW-1:0] run_q, run_d, ramp_q, ramp_d;
  flags_t            flags_q, flags_d;
  logic [LevelW-1:0] ref_level, level_d;
  hi_sel_e           hi_sel_d;
  lo_sel_e           lo_sel_d;

  always_comb begin
    ref_level = in_i.adc_ok ? LevelW'(in_i.adc_sample) * LevelW'(RefGain) : '0;
    mode_d    = mode_q;
    saved_d   = saved_q;
    toggle_d  = toggle_q || in_i.dir_press;
    run_d     = run_q;
    ramp_d    = ramp_q;
    flags_d   = flags_q;
    hi_sel_d  = HI_KEEP;
    lo_sel_d  = LO_KEEP;
    level_d   = ref_level;

    // toggle waits while stopping
    if (toggle_d && mode_d != MODE_STOP) begin
      toggle_d = 1'b0;
      mode_d   = (mode_d == MODE_A) ? MODE_B : MODE_A;
      saved_d  = (mode_d == MODE_B);
    end

    if (in_i.stop_press) begin
      if (mode_d == MODE_STOP) begin
        mode_d      = saved_d ? MODE_B : MODE_A;
        flags_d.led = 1'b0;
      end else begin
        saved_d = (mode_d == MODE_B);
        ramp_d  = run_q;
        mode_d  = MODE_STOP;
      end
    end

    unique case (mode_d)
      MODE_STOP: begin
        ramp_d  = (ramp_d > ramp_step_q) ? ramp_d - ramp_step_q : '0;
        level_d = ramp_d;
        if (ramp_d == '0) begin
          flags_d = FlagsLed;
        end else if (!saved_d) begin
          hi_sel_d     = HI_TICKS;
          flags_d.low  = 1'b0;
          flags_d.high = 1'b1;
        end else begin
          lo_sel_d     = LO_TICKS;
          flags_d.high = 1'b0;
          flags_d.low  = 1'b1;
        end
      end
      MODE_A: begin
        run_d       = ref_level;
        flags_d.led = 1'b0;
        if (!flags_d.high) begin
          flags_d.cnt = 1'b1;
          lo_sel_d    = LO_ARM;
        end
        hi_sel_d     = HI_TICKS;
        flags_d.low  = 1'b0;
        flags_d.high = 1'b1;
      end
      default: begin
        run_d       = ref_level;
        flags_d.led = 1'b0;
        if (!flags_d.low) begin
          flags_d.cnt = 1'b1;
          hi_sel_d    = HI_MIN;
        end
        lo_sel_d     = LO_TICKS;
        flags_d.high = 1'b0;
        flags_d.low  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_A;
      saved_q  <= 1'b0;
      toggle_q <= 1'b0;
      run_q    <= '0;
      ramp_q   <= '0;
      flags_q  <= FlagsRst;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      saved_q  <= saved_d;
      toggle_q <= toggle_d;
      run_q    <= run_d;
      ramp_q   <= ramp_d;
      flags_q  <= flags_d;
    end
  end

  ctrl_t             s1_ctrl_q, s2_ctrl_q, s3_ctrl_q, s4_ctrl_q;
  logic [LevelW-1:0] s1_level_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_ctrl_q  <= '{hi_sel: hi_sel_d, lo_sel: lo_sel_d, flags: flags_d,
                      drive_mode: mode_code(mode_d)};
      s1_level_q <= level_d;
    end
  end

  // ---------------- stage 2: level x period ----------------
  logic [ProdW-1:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_ctrl_q <= s1_ctrl_q;
      s2_prod_q <= ProdW'(s1_level_q) * ProdW'(period_q);
    end
  end

  // ---------------- stage 3: reciprocal partial products ----------------
  logic [XLoW-1:0]          x_lo;
  logic [ProdW-XLoW-1:0]    x_hi;
  logic [PpW-1:0]           pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  localparam logic [RecipLoW-1:0]        RecipLo = Recip[RecipLoW-1:0];
  localparam logic [RecipW-RecipLoW-1:0] RecipHi = Recip[RecipW-1:RecipLoW];

  assign x_lo = s2_prod_q[XLoW-1:0];
  assign x_hi = s2_prod_q[ProdW-1:XLoW];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_ctrl_q <= s2_ctrl_q;
      pp_ll_q   <= PpW'(x_lo) * PpW'(RecipLo);
      pp_lh_q   <= PpW'(x_lo) * PpW'(RecipHi);
      pp_hl_q   <= PpW'(x_hi) * PpW'(RecipLo);
      pp_hh_q   <= PpW'(x_hi) * PpW'(RecipHi);
    end
  end

  // ---------------- stage 4: sum and take the quotient ----------------
  logic [SumW-1:0] pp_sum;
  logic [CmpW-1:0] s4_quot_q;

  assign pp_sum = SumW'(pp_ll_q)
                + (SumW'(pp_lh_q) << RecipLoW)
                + (SumW'(pp_hl_q) << XLoW)
                + (SumW'(pp_hh_q) << (XLoW + RecipLoW));

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_ctrl_q <= s3_ctrl_q;
      s4_quot_q <= pp_sum[RecipShift +: CmpW];
    end
  end

  // ---------------- stage 5: compare select, output register ----------------
  logic [CmpW-1:0]  ticks, high_new, low_new;
  logic [CmpW-1:0]  high_q, low_q;
  flags_t           out_flags_q;
  logic [ModeW-1:0] out_mode_q;

  always_comb begin
    ticks = s4_quot_q;
    if (ticks < min_cmp_q) ticks = min_cmp_q;
    if (ticks > period_q)  ticks = period_q;   // period limit wins over the minimum

    case (s4_ctrl_q.hi_sel)
      HI_TICKS: high_new = ticks;
      HI_MIN:   high_new = min_cmp_q;
      default:  high_new = high_q;
    endcase

    case (s4_ctrl_q.lo_sel)
      LO_TICKS: low_new = cap_low({1'b0, ticks} + {1'b0, dead_q}, period_q);
      LO_ARM:   low_new = cap_low({1'b0, min_cmp_q} + {1'b0, dead_q}, period_q);
      default:  low_new = low_q;
    endcase
  end

  // output payload doubles as the compare state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q      <= HighCmpRst;
      low_q       <= LowCmpRst;
      out_flags_q <= FlagsRst;
      out_mode_q  <= DriveA;
    end else if (en_out && v4_q) begin
      high_q      <= high_new;
      low_q       <= low_new;
      out_flags_q <= s4_ctrl_q.flags;
      out_mode_q  <= s4_ctrl_q.drive_mode;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.high_compare   = high_q;
  assign out_o.low_on_compare = low_q;
  assign out_o.high_enable    = out_flags_q.high;
  assign out_o.low_enable     = out_flags_q.low;
  assign out_o.counter_run    = out_flags_q.cnt;
  assign out_o.stop_led       = out_flags_q.led;
  assign out_o.drive_mode     = out_mode_q;

  // ---------------- assertions ----------------
  a_bridge_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_flags_q.high && out_flags_q.low))
    else $error("both bridge sides enabled");

  a_led_means_all_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flags_q.led |->
      !out_flags_q.high && !out_flags_q.low && !out_flags_q.cnt)
    else $error("stop LED on while outputs or counter run");

  a_led_only_when_stopping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.led |-> mode_q == MODE_STOP)
    else $error("stop LED state set outside stopping mode");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en_out |=> v4_q && $stable(s4_ctrl_q) && $stable(s4_quot_q))
    else $error("pipeline stage dropped a transaction under stall");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for hbridge_direction_soft_stop_pwm: drives control ticks,
// predicts the PWM result of each one and checks it field by field.
// Depends on hbdss_pkg and the channel interfaces from the RTL.
`timescale 1ns / 100ps

module testbench;
  import hbdss_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned ShownMax   = 10;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               ok;
    logic               stop;
    logic               dir;
  } tick_t;

  typedef struct packed {
    logic [CmpW-1:0]  high_cmp;
    logic [CmpW-1:0]  low_cmp;
    logic             high_en;
    logic             low_en;
    logic             cnt_run;
    logic             led;
    logic [ModeW-1:0] mode;
  } pwm_result_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic pready;

  hbdss_in_if  tick_bus ();
  hbdss_out_if pwm_bus ();

  hbridge_direction_soft_stop_pwm dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_bus),
    .out_o   (pwm_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Register copy and drive state of the predictor
  logic [CmpW-1:0]   cfg_period;
  logic [CmpW-1:0]   cfg_dead;
  logic [CmpW-1:0]   cfg_min_cmp;
  logic [LevelW-1:0] cfg_ramp;

  logic [ModeW-1:0]  mode_q;
  logic              saved_dir;
  logic              toggle_wait;
  logic [LevelW-1:0] run_lvl;
  logic [LevelW-1:0] ramp_lvl;
  logic [CmpW-1:0]   high_cmp;
  logic [CmpW-1:0]   low_cmp;
  flags_t            flags;

  tick_t       tick_q[$];
  pwm_result_t pwm_expect_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned gap_left;
  int unsigned drv_calm;
  int unsigned hold_left;
  int unsigned rcv_calm;
  int unsigned hold_asked;
  int unsigned hold_served;
  pwm_result_t got_res;
  pwm_result_t want_res;

  // ---------------------------------------------------------------------------
  // Predictor

  function automatic logic [CmpW-1:0] duty_ticks(logic [LevelW-1:0] level);
    logic [63:0] t;
    t = (64'(level) * 64'(cfg_period)) / 64'(LevelScale);
    if (t < 64'(cfg_min_cmp)) t = 64'(cfg_min_cmp);
    if (t > 64'(cfg_period)) t = 64'(cfg_period);
    return t[CmpW-1:0];
  endfunction

  // low-side compare may not reach the period
  function automatic logic [CmpW-1:0] low_limit(logic [CmpW:0] v);
    logic [CmpW:0] r;
    r = v;
    if (v >= {1'b0, cfg_period}) r = (cfg_period == '0) ? '0 : {1'b0, cfg_period} - 1'b1;
    return r[CmpW-1:0];
  endfunction

  function automatic void drive_side(logic side_b, logic [LevelW-1:0] level);
    if (side_b) begin
      low_cmp = low_limit({1'b0, duty_ticks(level)} + {1'b0, cfg_dead});
      flags.high = 1'b0;
      flags.low = 1'b1;
    end else begin
      high_cmp = duty_ticks(level);
      flags.low = 1'b0;
      flags.high = 1'b1;
    end
  endfunction

  function automatic pwm_result_t next_pwm(tick_t t);
    logic [LevelW-1:0] ref_lvl;
    pwm_result_t r;
    if (t.dir) toggle_wait = 1'b1;
    // a toggle waits while stopping
    if (toggle_wait && mode_q != DriveStop) begin
      toggle_wait = 1'b0;
      mode_q = (mode_q == DriveA) ? DriveB : DriveA;
      saved_dir = mode_q[0];
    end
    if (t.stop) begin
      if (mode_q == DriveStop) begin
        mode_q = {1'b0, saved_dir};
        flags.led = 1'b0;
      end else begin
        saved_dir = mode_q[0];
        ramp_lvl = run_lvl;
        mode_q = DriveStop;
      end
    end
    ref_lvl = t.ok ? LevelW'(64'(t.sample) * 64'(LevelScale) / 64'(AdcFull)) : '0;
    if (mode_q == DriveStop) begin
      ramp_lvl = (ramp_lvl > cfg_ramp) ? ramp_lvl - cfg_ramp : '0;
      if (ramp_lvl == '0) flags = FlagsLed;
      else drive_side(saved_dir, ramp_lvl);
    end else begin
      run_lvl = ref_lvl;
      flags.led = 1'b0;
      if ((mode_q == DriveA && !flags.high) || (mode_q == DriveB && !flags.low)) begin
        high_cmp = cfg_min_cmp;
        low_cmp = low_limit({1'b0, cfg_min_cmp} + {1'b0, cfg_dead});
        flags.cnt = 1'b1;
      end
      drive_side(mode_q == DriveB, run_lvl);
    end
    r.high_cmp = high_cmp;
    r.low_cmp = low_cmp;
    r.high_en = flags.high;
    r.low_en = flags.low;
    r.cnt_run = flags.cnt;
    r.led = flags.led;
    r.mode = mode_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers

  // mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    return n;
  endfunction

  function automatic void push_tick(int unsigned sample, bit ok, bit stop, bit dir);
    tick_t t;
    t.sample = SampleW'(sample);
    t.ok = ok;
    t.stop = stop;
    t.dir = dir;
    tick_q.push_back(t);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) t.sample = '0;
    else if (r < 20) t.sample = '1;
    else if (r < 32) t.sample = SampleW'($urandom_range(1, 20));
    else t.sample = SampleW'($urandom);
    t.ok = ($urandom_range(0, 99) < 92);
    t.stop = ($urandom_range(0, 99) < 7);
    t.dir = ($urandom_range(0, 99) < 8);
    return t;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= ShownMax)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || tick_bus.valid || pwm_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // write, then read back
  task automatic cfg_write(cfg_reg_e idx, logic [DataW-1:0] val);
    logic [DataW-1:0] masked;
    masked = (idx == REG_RAMP_STEP) ? (val & 32'h003f_ffff) : (val & 32'h0000_ffff);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    check_field("register readback", masked, prdata);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PERIOD:    cfg_period = masked[CmpW-1:0];
      REG_DEAD:      cfg_dead = masked[CmpW-1:0];
      REG_MIN_CMP:   cfg_min_cmp = masked[CmpW-1:0];
      REG_RAMP_STEP: cfg_ramp = masked[LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [DataW-1:0] period, logic [DataW-1:0] dead,
                           logic [DataW-1:0] min_cmp, logic [DataW-1:0] ramp,
                           int unsigned count, bit squeeze);
    cfg_write(REG_PERIOD, period);
    cfg_write(REG_DEAD, dead);
    cfg_write(REG_MIN_CMP, min_cmp);
    cfg_write(REG_RAMP_STEP, ramp);
    repeat (count) tick_q.push_back(rand_tick());
    if (squeeze) hold_asked++;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_bus.valid = 1'b0;
    tick_bus.adc_sample = '0;
    tick_bus.adc_ok = 1'b0;
    tick_bus.stop_press = 1'b0;
    tick_bus.dir_press = 1'b0;
    pwm_bus.ready = 1'b0;
    errors = 0;
    hold_asked = 0;
    cfg_period = PeriodRst;
    cfg_dead = DeadRst;
    cfg_min_cmp = MinCmpRst;
    cfg_ramp = RampStepRst;
    mode_q = DriveA;
    saved_dir = 1'b0;
    toggle_wait = 1'b0;
    run_lvl = '0;
    ramp_lvl = '0;
    high_cmp = HighCmpRst;
    low_cmp = LowCmpRst;
    flags = FlagsRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks at reset settings
    push_tick(0, 1, 0, 0);
    push_tick(4095, 1, 0, 0);
    push_tick(4095, 0, 0, 0);
    push_tick(2048, 1, 0, 0);
    push_tick(100, 1, 0, 1);      // to direction B, re-arm
    push_tick(4095, 1, 0, 0);
    push_tick(0, 1, 0, 0);
    push_tick(1, 1, 0, 0);
    push_tick(1, 1, 1, 0);        // stop; ramp ends at once, LED on
    push_tick(4095, 1, 0, 0);
    push_tick(4095, 1, 0, 1);     // toggle waits while stopping
    push_tick(2000, 1, 1, 0);     // resume saved direction
    push_tick(3000, 1, 0, 0);     // waiting toggle applies
    push_tick(4095, 1, 0, 0);
    push_tick(4095, 1, 1, 0);     // slow ramp from full level
    push_tick(0, 1, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(0, 1, 1, 1);        // resume and toggle press in one tick; the toggle applies on the next tick
    push_tick(4095, 1, 0, 0);
    push_tick(500, 1, 1, 1);      // toggle, then stop the new direction
    push_tick(500, 1, 1, 0);
    push_tick(4095, 0, 0, 1);
    push_tick(4095, 1, 0, 0);
    wait_idle();

    run_phase(17000, 680, 3, 4095, 130, 1'b0);
    run_phase(65535, 65535, 0, 4095000, 200, 1'b0);
    run_phase(4, 0, 65535, 1, 130, 1'b0);              // minimum above period
    run_phase(0, 3, 2, 0, 100, 1'b0);                  // zero period, ramp never falls
    run_phase(1000, 10, 5, 300000, 200, 1'b1);         // long receiver hold-off
    run_phase($urandom, $urandom, $urandom, $urandom, 200, 1'b0);
    run_phase($urandom, $urandom, $urandom_range(0, 600), $urandom, 200, 1'b0);
    run_phase(65535, 0, 0, 32'hffff_ffff, 150, 1'b1);

    if (errors == 0 && pwm_expect_q.size() == 0) begin
      $display("hbridge_direction_soft_stop_pwm regression: pass");
    end else begin
      $display("hbridge_direction_soft_stop_pwm regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tick driver: predicts each transaction as it is accepted

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_bus.valid <= 1'b0;
      gap_left = 0;
      drv_calm = 0;
    end else begin
      if (drv_calm > 0) drv_calm--;
      else if ($urandom_range(0, 149) == 0) drv_calm = $urandom_range(40, 160);
      if (tick_bus.valid && tick_bus.ready) begin
        pwm_expect_q.push_back(next_pwm(tick_q.pop_front()));
        gap_left = (drv_calm > 0) ? 0 : idle_len();
      end
      if (!(tick_bus.valid && !tick_bus.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_bus.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_bus.valid <= 1'b1;
          tick_bus.adc_sample <= tick_q[0].sample;
          tick_bus.adc_ok <= tick_q[0].ok;
          tick_bus.stop_press <= tick_q[0].stop;
          tick_bus.dir_press <= tick_q[0].dir;
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_bus.ready <= 1'b0;
      hold_left = 0;
      rcv_calm = 0;
      hold_served = 0;
    end else begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = LongHold;
      end
      if (rcv_calm > 0) rcv_calm--;
      else if ($urandom_range(0, 149) == 0) rcv_calm = $urandom_range(40, 160);
      if (hold_left > 0) begin
        hold_left--;
        pwm_bus.ready <= 1'b0;
      end else if (rcv_calm == 0 && $urandom_range(0, 99) < 25) begin
        hold_left = idle_len();
        pwm_bus.ready <= (hold_left == 0);
      end else begin
        pwm_bus.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && pwm_bus.valid && pwm_bus.ready) begin
      got_res.high_cmp = pwm_bus.high_compare;
      got_res.low_cmp = pwm_bus.low_on_compare;
      got_res.high_en = pwm_bus.high_enable;
      got_res.low_en = pwm_bus.low_enable;
      got_res.cnt_run = pwm_bus.counter_run;
      got_res.led = pwm_bus.stop_led;
      got_res.mode = pwm_bus.drive_mode;
      if (pwm_expect_q.size() == 0) begin
        errors++;
        if (errors <= ShownMax)
          $display("unexpected result transaction: 0x%0h", got_res);
      end else begin
        want_res = pwm_expect_q.pop_front();
        check_field("high_compare", want_res.high_cmp, got_res.high_cmp);
        check_field("low_on_compare", want_res.low_cmp, got_res.low_cmp);
        check_field("high_enable", want_res.high_en, got_res.high_en);
        check_field("low_enable", want_res.low_en, got_res.low_en);
        check_field("counter_run", want_res.cnt_run, got_res.cnt_run);
        check_field("stop_led", want_res.led, got_res.led);
        check_field("drive_mode", want_res.mode, got_res.mode);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("hbridge_direction_soft_stop_pwm regression: fail");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
